FILE: rtl/core/bmp24_to_rgb565_stream_macros.svh
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_stream_macros.svh
// Assertion macros used by the checker file bmprgb_chk.
// ----------------------------------------------------------------------------
`ifndef BMP24_TO_RGB565_STREAM_MACROS_SVH
`define BMP24_TO_RGB565_STREAM_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BMPRGB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMPRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bmprgb_pkg.sv
// ----------------------------------------------------------------------------
// bmprgb_pkg
// Types and constants for the BMP 24-bit to RGB565 stream converter.
// ----------------------------------------------------------------------------
package bmprgb_pkg;

    localparam int MAX_WIDTH = 320;
    localparam int COL_W     = $clog2(MAX_WIDTH + 1);

    localparam logic [5:0]  HDR_LAST     = 6'd53;
    localparam logic [31:0] HEADER_BYTES = 32'd54;
    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BMP_BITS      = 16'd24;

    // header field byte positions
    localparam logic [5:0] OFS_SIG    = 6'd0;
    localparam logic [5:0] OFS_OFFSET = 6'd10;
    localparam logic [5:0] OFS_WIDTH  = 6'd18;
    localparam logic [5:0] OFS_HEIGHT = 6'd22;
    localparam logic [5:0] OFS_BITS   = 6'd28;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    localparam logic [1:0] BIP_BLUE  = 2'd0;
    localparam logic [1:0] BIP_GREEN = 2'd1;
    localparam logic [1:0] BIP_RED   = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_PIXELS = 3'd2,
        PH_DONE   = 3'd3,
        PH_REJECT = 3'd4
    } phase_t;

    typedef struct packed {
        logic [15:0] pixel_rgb565;
        logic        result_kind;
        logic        row_end;
        logic        image_end;
    } result_t;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

FILE: rtl/core/bmprgb_parse.sv
// ----------------------------------------------------------------------------
// bmprgb_parse
// Header capture, offset skip and pixel packing; one byte per transfer.
// ----------------------------------------------------------------------------
module bmprgb_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [15:0]         cfg_data,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    input  logic                file_start,
    output logic                res_valid,
    output bmprgb_pkg::result_t res
);
    import bmprgb_pkg::*;

    logic [15:0]      row_limit_reg;
    logic [31:0]      pos_reg, pos_cur, pos_next;
    phase_t           phase_reg, phase_cur, phase_next;
    logic [31:0]      row_reg, row_cur, row_next;
    logic [COL_W-1:0] col_reg, col_cur, col_next;
    logic [1:0]       bip_reg, bip_cur, bip_next;

    logic [15:0] sig_reg;
    logic [31:0] off_reg;
    logic [31:0] width_reg;
    logic [31:0] height_reg;
    logic [15:0] bits_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  green_reg;

    logic [5:0]   hdr_idx;
    logic         hdr_bad;
    logic         skip_done;
    logic         do_pix;
    logic [COL_W:0] col_plus;
    logic         last_col;
    logic [31:0]  row_plus;
    logic         last_row;
    logic         emit;

    assign phase_cur = file_start ? PH_HEADER : phase_reg;
    assign pos_cur   = file_start ? 32'd0 : pos_reg;
    assign row_cur   = file_start ? 32'd0 : row_reg;
    assign col_cur   = file_start ? '0 : col_reg;
    assign bip_cur   = file_start ? BIP_BLUE : bip_reg;

    assign hdr_idx  = pos_cur[5:0];
    assign hdr_bad  = (sig_reg != BMP_SIGNATURE) || (bits_reg != BMP_BITS)
                   || (width_reg == 32'd0) || (width_reg > 32'(MAX_WIDTH))
                   || (off_reg < HEADER_BYTES);

    assign skip_done = (pos_cur == off_reg);
    assign do_pix    = (phase_cur == PH_PIXELS) || ((phase_cur == PH_SKIP) && skip_done);

    assign col_plus = {1'b0, col_cur} + {{COL_W{1'b0}}, 1'b1};
    assign last_col = col_plus >= {1'b0, width_reg[COL_W-1:0]};
    assign row_plus = row_cur + 32'd1;
    assign last_row = row_plus >= height_reg;
    assign emit     = (height_reg - row_cur) < {16'd0, row_limit_reg};

    always_comb
    begin
        phase_next = phase_cur;
        pos_next   = pos_cur;
        row_next   = row_cur;
        col_next   = col_cur;
        bip_next   = bip_cur;
        res_valid  = 1'b0;
        res        = '0;

        if (phase_cur == PH_HEADER)
        begin
            pos_next = pos_cur + 32'd1;
            if (hdr_idx == HDR_LAST)
            begin
                row_next = '0;
                col_next = '0;
                bip_next = BIP_BLUE;
                priority if (hdr_bad)
                begin
                    phase_next      = PH_REJECT;
                    res_valid       = in_fire;
                    res.result_kind = KIND_REJECT;
                end
                else if ((height_reg == 32'd0) || height_reg[31])
                    phase_next = PH_DONE;
                else if (off_reg == HEADER_BYTES)
                    phase_next = PH_PIXELS;
                else
                    phase_next = PH_SKIP;
            end
        end
        else if ((phase_cur == PH_SKIP) && !skip_done)
            pos_next = pos_cur + 32'd1;
        else if (do_pix)
        begin
            phase_next = PH_PIXELS;
            unique case (bip_cur)
                BIP_BLUE:  bip_next = BIP_GREEN;
                BIP_GREEN: bip_next = BIP_RED;
                default:
                begin
                    bip_next = BIP_BLUE;
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = row_plus;
                        if (last_row)
                            phase_next = PH_DONE;
                    end
                    else
                        col_next = col_plus[COL_W-1:0];
                    res_valid        = in_fire && emit;
                    res.pixel_rgb565 = pack565(data_byte, green_reg, blue_reg);
                    res.result_kind  = KIND_PIXEL;
                    res.row_end      = last_col;
                    res.image_end    = last_col && last_row;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg <= 16'hFFFF;
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            bip_reg       <= BIP_BLUE;
        end
        else
        begin
            if (cfg_write)
                row_limit_reg <= cfg_data;
            if (in_fire)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                row_reg   <= row_next;
                col_reg   <= col_next;
                bip_reg   <= bip_next;
            end
        end
    end

    // header fields and color bytes are always written before use
    always_ff @(posedge clk)
    begin
        if (in_fire && (phase_cur == PH_HEADER))
        begin
            unique case (hdr_idx)
                OFS_SIG:            sig_reg[7:0]      <= data_byte;
                OFS_SIG + 6'd1:     sig_reg[15:8]     <= data_byte;
                OFS_OFFSET:         off_reg[7:0]      <= data_byte;
                OFS_OFFSET + 6'd1:  off_reg[15:8]     <= data_byte;
                OFS_OFFSET + 6'd2:  off_reg[23:16]    <= data_byte;
                OFS_OFFSET + 6'd3:  off_reg[31:24]    <= data_byte;
                OFS_WIDTH:          width_reg[7:0]    <= data_byte;
                OFS_WIDTH + 6'd1:   width_reg[15:8]   <= data_byte;
                OFS_WIDTH + 6'd2:   width_reg[23:16]  <= data_byte;
                OFS_WIDTH + 6'd3:   width_reg[31:24]  <= data_byte;
                OFS_HEIGHT:         height_reg[7:0]   <= data_byte;
                OFS_HEIGHT + 6'd1:  height_reg[15:8]  <= data_byte;
                OFS_HEIGHT + 6'd2:  height_reg[23:16] <= data_byte;
                OFS_HEIGHT + 6'd3:  height_reg[31:24] <= data_byte;
                OFS_BITS:           bits_reg[7:0]     <= data_byte;
                OFS_BITS + 6'd1:    bits_reg[15:8]    <= data_byte;
                default:            ;
            endcase
        end
        if (in_fire && do_pix && (bip_cur == BIP_BLUE))
            blue_reg <= data_byte;
        if (in_fire && do_pix && (bip_cur == BIP_GREEN))
            green_reg <= data_byte;
    end

endmodule

FILE: rtl/core/bmprgb_obuf.sv
// ----------------------------------------------------------------------------
// bmprgb_obuf
// Two-entry output buffer: result register plus skid entry.
// ----------------------------------------------------------------------------
module bmprgb_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  bmprgb_pkg::result_t res,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output bmprgb_pkg::result_t out_data
);
    import bmprgb_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;
    logic    drain;

    assign drain = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || drain)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (drain)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/bmp24_to_rgb565_stream.sv
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_stream
// Parses a 24-bit BMP byte stream and emits RGB565 pixels or a reject status.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_stall    data_byte, file_start
//   out       source     out_valid / out_stall  pixel_rgb565, result_kind,
//                                               row_end, image_end
//   cfg       sink       cfg_write              cfg_data (row_limit)
//
// One byte per cycle while in_stall is low; a result appears in the output
// register in the cycle after the transfer that completes it (third byte of
// a pixel, header end) when that register is free or draining.
// Reset clears the parse state and sets row_limit to 65535.
// The output side holds two results; in_stall is high while both are
// occupied and drops the cycle after the sink takes a transfer.
// ----------------------------------------------------------------------------
module bmp24_to_rgb565_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel_rgb565,
    output logic        result_kind,
    output logic        row_end,
    output logic        image_end
);
    import bmprgb_pkg::*;

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    full;

    assign in_stall = full;
    assign in_fire  = in_valid && !full;

    bmprgb_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .data_byte  (data_byte),
        .file_start (file_start),
        .res_valid  (res_valid),
        .res        (res)
    );

    bmprgb_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign pixel_rgb565 = out_data.pixel_rgb565;
    assign result_kind  = out_data.result_kind;
    assign row_end      = out_data.row_end;
    assign image_end    = out_data.image_end;

endmodule

FILE: rtl/core/bmprgb_chk.sv
// ----------------------------------------------------------------------------
// bmprgb_chk
// Port-level checks for bmp24_to_rgb565_stream, attached by bind.
// ----------------------------------------------------------------------------
`include "bmp24_to_rgb565_stream_macros.svh"

module bmprgb_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] pixel_rgb565,
    input logic        result_kind,
    input logic        row_end,
    input logic        image_end
);

    `BMPRGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped while stalled")
    `BMPRGB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(pixel_rgb565) && $stable(result_kind) && $stable(row_end) && $stable(image_end), "payload changed while stalled")
    `BMPRGB_ASSERT_NOW(a_status_clean, out_valid && result_kind, (pixel_rgb565 == 16'd0) && !row_end && !image_end, "status transfer carries pixel data")
    `BMPRGB_ASSERT_NOW(a_image_end_row, out_valid && image_end, row_end && !result_kind, "image_end without row_end")

endmodule

bind bmp24_to_rgb565_stream bmprgb_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_rgb565 (pixel_rgb565),
    .result_kind  (result_kind),
    .row_end      (row_end),
    .image_end    (image_end)
);
